// ===== rtl/pgb_pkg.sv =====
`timescale 1ns / 1ps

package pgb_pkg;

  localparam int GAMMA_LEVELS_DEF = 19;

  localparam logic [14:0] KEY_COLOR      = 15'h2D9F;
  localparam logic [4:0]  KEY_SLOT       = 5'd16;
  localparam logic [4:0]  KEY_SLOT_FIRST = 5'd28;
  localparam logic [4:0]  KEY_SLOT_LAST  = 5'd31;
  localparam logic [4:0]  COEFF_MAX      = 5'd16;

  localparam int FULL_SCALE = 'h1F00;
  localparam int DARK_ROWS  = 3;
  localparam int SOFT_LIMIT = 11;

  localparam logic [1:0] CLASS_PASS = 2'd0;
  localparam logic [1:0] CLASS_A    = 2'd1;
  localparam logic [1:0] CLASS_B    = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_MAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_SLOT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_COEFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_TGT   = 3'd5;

  typedef struct packed {
    logic [4:0]  palette_slot;
    logic [14:0] color_in;
  } in_beat_t;

  typedef struct packed {
    logic [14:0] color_out;
    logic        write_enable;
  } out_beat_t;

  function automatic logic [4:0] clamp31(input int v);
    int q;
    begin
      q = v >>> 8;
      return (q > 31) ? 5'd31 : 5'(q);
    end
  endfunction

  // one entry of the generated gamma curves; tsel 0 is the darkening table
  function automatic logic [4:0] gamma_entry(input int tsel, input int row, input int ch);
    int acc;
    int drop;
    int base;
    int step;
    int over;
    begin
      acc  = ch * 256;
      drop = (tsel == 0) ? ch * 16 : 0;
      for (int r = 0; r < DARK_ROWS; r++) begin
        acc = acc - drop;
        if (r == row) begin
          return clamp31(acc);
        end
      end
      base = acc;
      step = (FULL_SCALE - acc) >>> 4;
      for (int r = DARK_ROWS; r <= row; r++) begin
        acc = acc + step;
        if (ch <= SOFT_LIMIT) begin
          over = acc - base;
          if (over > 0) begin
            acc = acc - (over >>> 1);
          end
        end
      end
      return clamp31(acc);
    end
  endfunction

endpackage

// ===== rtl/pgb_gamma_rom.sv =====
`timescale 1ns / 1ps

module pgb_gamma_rom
  import pgb_pkg::*;
#(
  parameter int GAMMA_LEVELS = GAMMA_LEVELS_DEF,
  parameter int ROW_W        = 5
) (
  input  logic             clk,
  input  logic             tsel,
  input  logic [ROW_W-1:0] row,
  input  logic [4:0]       chan,
  output logic [4:0]       rd_data_r
);

  localparam int ROWS   = 2 * GAMMA_LEVELS;
  localparam int DEPTH  = ROWS * 32;
  localparam int ROWS_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic [4:0] rom_t [DEPTH];

  function automatic rom_t rom_build();
    rom_t r;
    begin
      for (int t = 0; t < 2; t++) begin
        for (int w = 0; w < GAMMA_LEVELS; w++) begin
          for (int c = 0; c < 32; c++) begin
            r[(t * GAMMA_LEVELS + w) * 32 + c] = gamma_entry(t, w, c);
          end
        end
      end
      return r;
    end
  endfunction

  localparam rom_t ROM = rom_build();

  logic [ROWS_W-1:0] row_sel;

  // table B sits after all rows of table A
  assign row_sel = (tsel ? ROWS_W'(GAMMA_LEVELS) : ROWS_W'(0)) + ROWS_W'(row);

  always_ff @(posedge clk) begin
    rd_data_r <= ROM[{row_sel, chan}];
  end

endmodule

// ===== rtl/palette_gamma_blend.sv =====
// an accepted color passes the stage a to d registers in order to out_beat
// throughput: one color per cycle, busy stays low outside reset
// out_valid strobes for exactly one cycle per color; the receiver cannot stall
// reset (rst_n low, synchronous) empties the pipeline, clears the valid bits and
// the configuration registers; the gamma curves are constant tables
`timescale 1ns / 1ps

module palette_gamma_blend
  import pgb_pkg::*;
#(
  parameter int GAMMA_LEVELS = GAMMA_LEVELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  output out_beat_t            out_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int ROW_W = (GAMMA_LEVELS > 1) ? $clog2(GAMMA_LEVELS) : 1;

  // configuration
  logic [63:0] class_map_r;
  logic [3:0]  sprite_slot_r;
  logic        blend_mode_r;
  logic [4:0]  gamma_level_r;
  logic [4:0]  blend_coeff_r;
  logic [14:0] blend_target_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_map_r    <= '0;
      sprite_slot_r  <= '0;
      blend_mode_r   <= 1'b0;
      gamma_level_r  <= '0;
      blend_coeff_r  <= '0;
      blend_target_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLASS_MAP:   class_map_r    <= cfg_data;
        REG_SPRITE_SLOT: sprite_slot_r  <= cfg_data[3:0];
        REG_BLEND_MODE:  blend_mode_r   <= cfg_data[0];
        REG_GAMMA_LEVEL: gamma_level_r  <= cfg_data[4:0];
        REG_BLEND_COEFF: blend_coeff_r  <= cfg_data[4:0];
        REG_BLEND_TGT:   blend_target_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic in_accept;

  assign busy      = !rst_n;
  assign in_accept = start && !busy;

  // stage a: slot class and table decision
  logic [1:0]       cls;
  logic             sprite_hit;
  logic [4:0]       level_c;
  logic             gam_en_nxt;
  logic             skip_nxt;
  logic             tsel_nxt;
  logic [ROW_W-1:0] row_nxt;

  always_comb begin
    cls        = 2'(class_map_r >> {in_beat.palette_slot, 1'b0});
    sprite_hit = in_beat.palette_slot[4] && (in_beat.palette_slot[3:0] == sprite_slot_r);
    level_c    = (gamma_level_r > 5'(GAMMA_LEVELS)) ? 5'(GAMMA_LEVELS) : gamma_level_r;
    row_nxt    = ROW_W'(level_c - 5'd1);
    gam_en_nxt = (cls != CLASS_PASS) && (level_c != 5'd0);
    skip_nxt   = 1'b0;
    if (blend_mode_r) begin
      tsel_nxt = (cls != CLASS_A);
    end else begin
      tsel_nxt = (cls == CLASS_B) || sprite_hit;
      skip_nxt = gam_en_nxt && (in_beat.color_in == KEY_COLOR)
                 && (in_beat.palette_slot inside {KEY_SLOT, [KEY_SLOT_FIRST:KEY_SLOT_LAST]});
    end
  end

  logic             a_valid_r;
  logic [14:0]      a_color_r;
  logic             a_gam_en_r;
  logic             a_skip_r;
  logic             a_tsel_r;
  logic             a_blend_r;
  logic [ROW_W-1:0] a_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    a_color_r  <= in_beat.color_in;
    a_gam_en_r <= gam_en_nxt;
    a_skip_r   <= skip_nxt;
    a_tsel_r   <= tsel_nxt;
    a_blend_r  <= blend_mode_r;
    a_row_r    <= row_nxt;
  end

  // stage b: one table read per channel
  logic [4:0]  rd_data [3];
  logic        b_valid_r;
  logic [14:0] b_color_r;
  logic        b_gam_en_r;
  logic        b_skip_r;
  logic        b_blend_r;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pgb_gamma_rom #(
      .GAMMA_LEVELS(GAMMA_LEVELS),
      .ROW_W       (ROW_W)
    ) u_rom (
      .clk      (clk),
      .tsel     (a_tsel_r),
      .row      (a_row_r),
      .chan     (a_color_r[5*i +: 5]),
      .rd_data_r(rd_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_color_r  <= a_color_r;
    b_gam_en_r <= a_gam_en_r;
    b_skip_r   <= a_skip_r;
    b_blend_r  <= a_blend_r;
  end

  // stage c: pick mapped or raw channel, weight the distance to the target
  logic [4:0]         coeff_k;
  logic [4:0]         chan_sel [3];
  logic signed [10:0] prod_nxt [3];

  assign coeff_k = (blend_coeff_r > COEFF_MAX) ? COEFF_MAX : blend_coeff_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chan_sel[i] = b_gam_en_r ? rd_data[i] : b_color_r[5*i +: 5];
      prod_nxt[i] = 11'(($signed({1'b0, blend_target_r[5*i +: 5]})
                      - $signed({1'b0, chan_sel[i]})) * $signed({1'b0, coeff_k}));
    end
  end

  logic               c_valid_r;
  logic [4:0]         c_chan_r [3];
  logic signed [10:0] c_prod_r [3];
  logic               c_skip_r;
  logic               c_blend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_chan_r  <= chan_sel;
    c_prod_r  <= prod_nxt;
    c_skip_r  <= b_skip_r;
    c_blend_r <= b_blend_r;
  end

  // stage d: floor of product over 16 is an arithmetic shift, wrap to 5 bits
  logic [6:0]  quo [3];
  logic [14:0] color_nxt;
  out_beat_t   out_beat_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo[i] = 7'(c_prod_r[i] >>> 4);
      if (c_blend_r) begin
        color_nxt[5*i +: 5] = c_chan_r[i] + quo[i][4:0];
      end else begin
        color_nxt[5*i +: 5] = c_chan_r[i];
      end
    end
    out_beat_nxt.color_out    = c_skip_r ? 15'd0 : color_nxt;
    out_beat_nxt.write_enable = !c_skip_r;
  end

  logic      out_valid_r;
  out_beat_t out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##4 out_valid)
    else $error("accepted color did not produce a result");

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, 4))
    else $error("result without a matching accepted color");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.write_enable |-> out_beat.color_out == 15'd0)
    else $error("skipped key color carries nonzero data");

  a_skip_gamma_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.write_enable |-> !$past(c_blend_r))
    else $error("key skip in blend mode");

endmodule
